FILE: rtl/core/sact_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Segment allocation table package
// Shared widths, codes, state type and entry layout of the allocation table.
// ----------------------------------------------------------------------------
package sact_pkg;

    localparam int MAX_REGIONS_DEF = 16;

    localparam int FUNC_W   = 2;
    localparam int SEG_W    = 11;
    localparam int POS_W    = 10;
    localparam int PID_W    = 8;
    localparam int STATUS_W = 2;
    localparam int MEM_W    = 16;
    localparam int END_W    = POS_W + 1;

    localparam logic [MEM_W-1:0] TOTAL_MEM_RESET = 16'hFFFF;
    localparam logic [MEM_W-1:0] FREE_MAX        = 16'hFFFF;

    localparam logic [FUNC_W-1:0] FUNC_ACCESS  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [SEG_W-1:0] segment;
        logic [POS_W-1:0] start;
        logic [POS_W-1:0] length;
        logic [PID_W-1:0] owner;
    } entry_t;

    // Outcome of comparing one stored region with the current request.
    typedef struct packed {
        logic hit;
        logic clash;
        logic owned;
    } cmp_t;

endpackage
`default_nettype wire

FILE: rtl/core/sact_entry_eval.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Region comparator
// Compares one stored region with the requested span: containment for an
// access check, inclusive overlap for an allocate, and ownership.
// ----------------------------------------------------------------------------
module sact_entry_eval
(
    input  var sact_pkg::entry_t                 entry,
    input  wire  [sact_pkg::SEG_W-1:0]           req_segment,
    input  wire  [sact_pkg::POS_W-1:0]           req_start,
    input  wire  [sact_pkg::POS_W-1:0]           req_length,
    input  wire  [sact_pkg::PID_W-1:0]           req_owner,
    output sact_pkg::cmp_t                       cmp
);

    logic [sact_pkg::END_W-1:0] e_lo;
    logic [sact_pkg::END_W-1:0] e_hi;
    logic [sact_pkg::END_W-1:0] r_lo;
    logic [sact_pkg::END_W-1:0] r_hi;

    always_comb
    begin
        e_lo = {1'b0, entry.start};
        e_hi = {1'b0, entry.start} + {1'b0, entry.length};
        r_lo = {1'b0, req_start};
        r_hi = {1'b0, req_start} + {1'b0, req_length};

        cmp.owned = (entry.owner == req_owner);
        cmp.hit   = cmp.owned && (entry.segment == req_segment)
                    && (e_lo <= r_lo) && (r_hi <= e_hi);
        // Either end of the request lies in the region, or the request
        // covers the region entirely.
        cmp.clash = ((e_lo <= r_lo) && (r_lo <= e_hi))
                    || ((e_lo <= r_hi) && (r_hi <= e_hi))
                    || ((r_lo <= e_lo) && (e_hi <= r_hi));
    end

endmodule
`default_nettype wire

FILE: rtl/core/segment_alloc_check_table_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Segment allocation table
// Region table with access check, allocate and per-process release.
// ----------------------------------------------------------------------------
// A request word is taken on a rising edge with start high and busy low.
// func selects an access check, an allocate or a release of every region of
// process_id. The region fields sit in a single-port synchronous memory; the
// valid bits and the free count are flip-flops.
// Each request sweeps the memory one entry per cycle; busy stays high from
// acceptance through the sweep and the drain and finish states. The result
// word (status and free_memory) appears with done high for one cycle,
// registered from the finish state, and a new request may be taken in that
// same cycle, so no new request is taken before the last result is out.
// The memory read port and the serial sweep bound the request rate. The table is
// written only in the final cycle of an allocate, after the sweep has ended,
// so reads and writes of one entry never overlap.
// The receiver cannot stall: each result word is valid for its single cycle.
// Reset clears the valid bits, loads the free count with 65535 and leaves the
// block idle. A cfg_we write clears the table and loads the free count with
// cfg_wdata; the user must issue it only while the block is idle (unchecked).
// ----------------------------------------------------------------------------
module segment_alloc_check_table_top
#(
    parameter int MAX_REGIONS = sact_pkg::MAX_REGIONS_DEF
)
(
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_we,
    input  wire  [sact_pkg::MEM_W-1:0]       cfg_wdata,
    input  wire                              start,
    output logic                             busy,
    input  wire  [sact_pkg::FUNC_W-1:0]      func,
    input  wire  [sact_pkg::SEG_W-1:0]       segment_number,
    input  wire  [sact_pkg::POS_W-1:0]       start_position,
    input  wire  [sact_pkg::POS_W-1:0]       span_length,
    input  wire  [sact_pkg::PID_W-1:0]       process_id,
    output logic                             done,
    output logic [sact_pkg::STATUS_W-1:0]    status,
    output logic [sact_pkg::MEM_W-1:0]       free_memory
);

    localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_REGIONS - 1);

    sact_pkg::state_t state_reg, state_next;

    logic [IDX_W-1:0]               addr_reg, addr_next;
    logic                           eval_reg, eval_next;
    logic [IDX_W-1:0]               eval_idx_reg, eval_idx_next;
    logic [MAX_REGIONS-1:0]         valid_reg, valid_next;
    logic [sact_pkg::MEM_W-1:0]     free_reg, free_next;
    logic                           hit_reg, hit_next;
    logic                           clash_reg, clash_next;
    logic                           slot_found_reg, slot_found_next;
    logic [IDX_W-1:0]               slot_reg, slot_next;
    logic                           done_reg, done_next;
    logic [sact_pkg::STATUS_W-1:0]  status_reg, status_next;
    logic [sact_pkg::MEM_W-1:0]     free_out_reg, free_out_next;

    logic [sact_pkg::FUNC_W-1:0]    func_reg;
    logic [sact_pkg::SEG_W-1:0]     seg_reg;
    logic [sact_pkg::POS_W-1:0]     lo_reg;
    logic [sact_pkg::POS_W-1:0]     len_reg;
    logic [sact_pkg::PID_W-1:0]     pid_reg;

    sact_pkg::entry_t               table_mem [MAX_REGIONS];
    sact_pkg::entry_t               rd_data_reg;
    sact_pkg::entry_t               wr_data;
    logic                           wr_en;
    logic                           rd_en;
    logic                           accept;
    logic                           finishing;

    sact_pkg::cmp_t                 cmp;
    logic                           cur_valid;
    logic [sact_pkg::MEM_W:0]       credit_sum;

    sact_entry_eval u_eval
    (
        .entry       (rd_data_reg),
        .req_segment (seg_reg),
        .req_start   (lo_reg),
        .req_length  (len_reg),
        .req_owner   (pid_reg),
        .cmp         (cmp)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sact_pkg::S_IDLE:
            begin
                if (start)
                begin
                    state_next = sact_pkg::S_SCAN;
                end
            end
            sact_pkg::S_SCAN:
            begin
                if (addr_reg == LAST_IDX)
                begin
                    state_next = sact_pkg::S_DRAIN;
                end
            end
            sact_pkg::S_DRAIN:
            begin
                state_next = sact_pkg::S_FINISH;
            end
            sact_pkg::S_FINISH:
            begin
                state_next = sact_pkg::S_IDLE;
            end
            default:
            begin
                state_next = sact_pkg::S_IDLE;
            end
        endcase
    end

    // State decoded outputs.
    always_comb
    begin
        busy      = 1'b1;
        rd_en     = 1'b0;
        finishing = 1'b0;
        unique case (state_reg)
            sact_pkg::S_IDLE:   busy      = 1'b0;
            sact_pkg::S_SCAN:   rd_en     = 1'b1;
            sact_pkg::S_DRAIN:  busy      = 1'b1;
            sact_pkg::S_FINISH: finishing = 1'b1;
            default:            busy      = 1'b1;
        endcase
    end

    assign accept = start && !busy;

    // Datapath.
    always_comb
    begin
        addr_next       = addr_reg;
        eval_next       = rd_en;
        eval_idx_next   = addr_reg;
        valid_next      = valid_reg;
        free_next       = free_reg;
        hit_next        = hit_reg;
        clash_next      = clash_reg;
        slot_found_next = slot_found_reg;
        slot_next       = slot_reg;
        done_next       = 1'b0;
        status_next     = status_reg;
        free_out_next   = free_out_reg;
        wr_en           = 1'b0;
        wr_data         = '{segment: seg_reg, start: lo_reg, length: len_reg,
                            owner: pid_reg};
        cur_valid       = valid_reg[eval_idx_reg];
        credit_sum      = {1'b0, free_reg}
                          + {{(sact_pkg::MEM_W - sact_pkg::POS_W + 1){1'b0}},
                             rd_data_reg.length};

        if (accept)
        begin
            addr_next       = '0;
            hit_next        = 1'b0;
            clash_next      = 1'b0;
            slot_found_next = 1'b0;
            slot_next       = '0;
        end

        if (rd_en)
        begin
            addr_next = IDX_W'(addr_reg + 1'b1);
        end

        // One entry is judged each cycle, in the cycle after its read.
        if (eval_reg)
        begin
            if (cur_valid)
            begin
                if (cmp.hit)
                begin
                    hit_next = 1'b1;
                end
                if (cmp.clash)
                begin
                    clash_next = 1'b1;
                end
                if ((func_reg == sact_pkg::FUNC_RELEASE) && cmp.owned)
                begin
                    valid_next[eval_idx_reg] = 1'b0;
                    free_next = credit_sum[sact_pkg::MEM_W] ? sact_pkg::FREE_MAX
                                : credit_sum[sact_pkg::MEM_W-1:0];
                end
            end
            else if (!slot_found_reg)
            begin
                slot_found_next = 1'b1;
                slot_next       = eval_idx_reg;
            end
        end

        if (finishing)
        begin
            done_next   = 1'b1;
            status_next = sact_pkg::ST_REFUSED;
            case (func_reg)
                sact_pkg::FUNC_ACCESS:
                begin
                    status_next = hit_reg ? sact_pkg::ST_OK : sact_pkg::ST_REFUSED;
                end
                sact_pkg::FUNC_ALLOC:
                begin
                    if (({{(sact_pkg::MEM_W - sact_pkg::POS_W){1'b0}}, len_reg}
                         > free_reg) || clash_reg)
                    begin
                        status_next = sact_pkg::ST_REFUSED;
                    end
                    else if (!slot_found_reg)
                    begin
                        status_next = sact_pkg::ST_FULL;
                    end
                    else
                    begin
                        status_next          = sact_pkg::ST_OK;
                        wr_en                = 1'b1;
                        valid_next[slot_reg] = 1'b1;
                        free_next = free_reg
                                    - {{(sact_pkg::MEM_W - sact_pkg::POS_W){1'b0}},
                                       len_reg};
                    end
                end
                sact_pkg::FUNC_RELEASE:
                begin
                    status_next = sact_pkg::ST_OK;
                end
                default:
                begin
                    status_next = sact_pkg::ST_REFUSED;
                end
            endcase
            free_out_next = free_next;
        end

        // A configuration write restarts the table from empty.
        if (cfg_we)
        begin
            valid_next = '0;
            free_next  = cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= sact_pkg::S_IDLE;
            addr_reg       <= '0;
            eval_reg       <= 1'b0;
            eval_idx_reg   <= '0;
            valid_reg      <= '0;
            free_reg       <= sact_pkg::TOTAL_MEM_RESET;
            hit_reg        <= 1'b0;
            clash_reg      <= 1'b0;
            slot_found_reg <= 1'b0;
            slot_reg       <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            addr_reg       <= addr_next;
            eval_reg       <= eval_next;
            eval_idx_reg   <= eval_idx_next;
            valid_reg      <= valid_next;
            free_reg       <= free_next;
            hit_reg        <= hit_next;
            clash_reg      <= clash_next;
            slot_found_reg <= slot_found_next;
            slot_reg       <= slot_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        free_out_reg <= free_out_next;
        if (accept)
        begin
            func_reg <= func;
            seg_reg  <= segment_number;
            lo_reg   <= start_position;
            len_reg  <= span_length;
            pid_reg  <= process_id;
        end
    end

    // Region store: one port, registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[slot_reg] <= wr_data;
        end
        else if (rd_en)
        begin
            rd_data_reg <= table_mem[addr_reg];
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign free_memory = free_out_reg;

endmodule
`default_nettype wire

FILE: rtl/core/sact_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Allocation table port checker
// Checks the request and result timing seen on the top level's ports.
// ----------------------------------------------------------------------------
module sact_checker
(
    input wire                              clk,
    input wire                              rst_n,
    input wire                              start,
    input wire                              busy,
    input wire                              done,
    input wire [sact_pkg::STATUS_W-1:0]     status
);

    // The result word comes out as the block returns to idle.
    a_done_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result word shown while busy");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted request did not start a sweep");

    a_done_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("sweep ended without a result word");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((status == sact_pkg::ST_OK) || (status == sact_pkg::ST_REFUSED)
                  || (status == sact_pkg::ST_FULL)))
        else $error("undefined status code");

endmodule

bind segment_alloc_check_table_top sact_checker u_sact_checker
(
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .status (status)
);
`default_nettype wire
